/* design/mme_pkg.sv */
// Package with types, codes and helpers shared by the matrix multiply engine.
`timescale 1ns / 1ps
`default_nettype none
package mme_pkg;

    localparam int unsigned MaxDim   = 16;
    localparam int unsigned IdxW     = $clog2(MaxDim);
    localparam int unsigned DimW     = IdxW + 1;
    localparam int unsigned AddrW    = 2 * IdxW;
    localparam int unsigned DataW    = 32;
    localparam int unsigned CfgIdxW  = 2;
    localparam int unsigned QDepth   = 2;
    localparam int unsigned QPtrW    = $clog2(QDepth);
    localparam int unsigned QCntW    = $clog2(QDepth + 1);

    // Input opcodes.
    localparam logic [1:0] OP_LOAD_A = 2'd0;
    localparam logic [1:0] OP_LOAD_B = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    // Command kinds handed from front to back.
    localparam logic [1:0] CMD_LOAD_A = 2'd0;
    localparam logic [1:0] CMD_LOAD_B = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;
    localparam logic [1:0] CMD_REJECT = 2'd3;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] REG_ROWS_A     = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_INNER_SIZE = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_COLS_B     = 2'd2;

    localparam logic [DimW-1:0] DIM_RESET = DimW'(MaxDim);

    typedef struct packed {
        logic [1:0]             opcode;
        logic [IdxW-1:0]        row_index;
        logic [IdxW-1:0]        col_index;
        logic signed [DataW-1:0] element_value;
    } t_in_item;

    typedef struct packed {
        logic signed [DataW-1:0] product_value;
        logic                    range_error;
    } t_out_item;

    typedef struct packed {
        logic [1:0]       kind;
        logic [IdxW-1:0]  row;
        logic [IdxW-1:0]  col;
        logic [DataW-1:0] value;
        logic [DimW-1:0]  len;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Clamp a dimension register to the store size.
    function automatic logic [DimW-1:0] sat_dim(input logic [DimW-1:0] d);
        sat_dim = (d > DimW'(MaxDim)) ? DimW'(MaxDim) : d;
    endfunction

endpackage
`default_nettype wire

/* design/mme_front.sv */
// Front end: holds configuration, range-checks input items, emits commands.
`timescale 1ns / 1ps
`default_nettype none
module mme_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [mme_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  wire logic [mme_pkg::DimW-1:0]      i_cfg_data,
    input  wire logic                          i_in_valid,
    input  wire mme_pkg::t_in_item             i_in_data,
    input  wire mme_pkg::t_q_status            i_q_status,
    output logic                               o_in_stall,
    output logic                               o_push,
    output mme_pkg::t_cmd                      o_cmd
);

    logic [mme_pkg::DimW-1:0] r_rows_a;
    logic [mme_pkg::DimW-1:0] r_inner;
    logic [mme_pkg::DimW-1:0] r_cols_b;

    logic [mme_pkg::DimW-1:0] nr;
    logic [mme_pkg::DimW-1:0] nk;
    logic [mme_pkg::DimW-1:0] nc;
    logic [mme_pkg::DimW-1:0] row_x;
    logic [mme_pkg::DimW-1:0] col_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a <= mme_pkg::DIM_RESET;
            r_inner  <= mme_pkg::DIM_RESET;
            r_cols_b <= mme_pkg::DIM_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mme_pkg::REG_ROWS_A:     r_rows_a <= i_cfg_data;
                mme_pkg::REG_INNER_SIZE: r_inner  <= i_cfg_data;
                mme_pkg::REG_COLS_B:     r_cols_b <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign nr    = mme_pkg::sat_dim(r_rows_a);
    assign nk    = mme_pkg::sat_dim(r_inner);
    assign nc    = mme_pkg::sat_dim(r_cols_b);
    assign row_x = {1'b0, i_in_data.row_index};
    assign col_x = {1'b0, i_in_data.col_index};

    assign o_in_stall = i_q_status.full;
    assign o_push     = i_in_valid && !i_q_status.full;

    always_comb begin
        o_cmd.row   = i_in_data.row_index;
        o_cmd.col   = i_in_data.col_index;
        o_cmd.value = i_in_data.element_value;
        o_cmd.len   = nk;
        o_cmd.kind  = mme_pkg::CMD_REJECT;
        unique case (i_in_data.opcode)
            mme_pkg::OP_LOAD_A:
                if (row_x < nr && col_x < nk) o_cmd.kind = mme_pkg::CMD_LOAD_A;
            mme_pkg::OP_LOAD_B:
                if (row_x < nk && col_x < nc) o_cmd.kind = mme_pkg::CMD_LOAD_B;
            mme_pkg::OP_QUERY:
                if (row_x < nr && col_x < nc) o_cmd.kind = mme_pkg::CMD_QUERY;
            default: o_cmd.kind = mme_pkg::CMD_REJECT;
        endcase
    end

endmodule
`default_nettype wire

/* design/mme_queue.sv */
// Two-entry command queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none
module mme_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire mme_pkg::t_cmd i_push_cmd,
    input  wire logic          i_pop,
    output mme_pkg::t_cmd      o_head,
    output mme_pkg::t_q_status o_status
);

    mme_pkg::t_cmd               r_mem [mme_pkg::QDepth];
    logic [mme_pkg::QPtrW-1:0]   r_wptr;
    logic [mme_pkg::QPtrW-1:0]   r_rptr;
    logic [mme_pkg::QCntW-1:0]   r_count;
    logic                        do_push;
    logic                        do_pop;

    assign o_status.full  = (r_count == mme_pkg::QCntW'(mme_pkg::QDepth));
    assign o_status.empty = (r_count == '0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_head  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) r_wptr <= r_wptr + 1'b1;
            if (do_pop)  r_rptr <= r_rptr + 1'b1;
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

/* design/mme_back.sv */
// Back end: element stores, multiply-accumulate sequencer and result register.
`timescale 1ns / 1ps
`default_nettype none
module mme_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire mme_pkg::t_cmd  i_head,
    input  wire mme_pkg::t_q_status i_q_status,
    output logic                o_pop,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output mme_pkg::t_out_item  o_out_data
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic [mme_pkg::DataW-1:0] mem_a [2**mme_pkg::AddrW];
    logic [mme_pkg::DataW-1:0] mem_b [2**mme_pkg::AddrW];

    logic                      r_state;
    logic [mme_pkg::IdxW-1:0]  r_row;
    logic [mme_pkg::IdxW-1:0]  r_col;
    logic [mme_pkg::DimW-1:0]  r_len;
    logic [mme_pkg::DimW-1:0]  r_k;
    logic                      r_rd_vld;
    logic                      r_mul_vld;
    logic [mme_pkg::DataW-1:0] r_a_q;
    logic [mme_pkg::DataW-1:0] r_b_q;
    logic [mme_pkg::DataW-1:0] r_prod;
    logic [mme_pkg::DataW-1:0] r_acc;
    logic                      r_out_valid;
    mme_pkg::t_out_item        r_out;

    logic                      out_free;
    logic                      issue;
    logic                      done;
    logic                      we_a;
    logic                      we_b;
    logic [mme_pkg::AddrW-1:0] waddr;
    logic [mme_pkg::AddrW-1:0] raddr_a;
    logic [mme_pkg::AddrW-1:0] raddr_b;

    assign out_free = !r_out_valid || !i_out_stall;
    assign o_pop    = (r_state == ST_IDLE) && !i_q_status.empty && out_free;
    assign issue    = (r_state == ST_RUN) && (r_k < r_len);
    assign done     = (r_state == ST_RUN) && (r_k == r_len) && !r_rd_vld && !r_mul_vld;
    assign we_a     = o_pop && (i_head.kind == mme_pkg::CMD_LOAD_A);
    assign we_b     = o_pop && (i_head.kind == mme_pkg::CMD_LOAD_B);
    assign waddr    = {i_head.row, i_head.col};
    assign raddr_a  = {r_row, r_k[mme_pkg::IdxW-1:0]};
    assign raddr_b  = {r_k[mme_pkg::IdxW-1:0], r_col};

    always_ff @(posedge i_clk) begin
        if (we_a) mem_a[waddr] <= i_head.value;
        r_a_q <= mem_a[raddr_a];
    end

    always_ff @(posedge i_clk) begin
        if (we_b) mem_b[waddr] <= i_head.value;
        r_b_q <= mem_b[raddr_b];
    end

    // Datapath: read, multiply, accumulate, one stage each.
    always_ff @(posedge i_clk) begin
        r_prod <= r_a_q * r_b_q;
        if (o_pop) begin
            r_row <= i_head.row;
            r_col <= i_head.col;
            r_len <= i_head.len;
            r_acc <= '0;
        end else if (r_mul_vld) begin
            r_acc <= r_acc + r_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_k       <= '0;
            r_rd_vld  <= 1'b0;
            r_mul_vld <= 1'b0;
        end else begin
            r_rd_vld  <= issue;
            r_mul_vld <= r_rd_vld;
            unique case (r_state)
                ST_IDLE: begin
                    r_k <= '0;
                    if (o_pop && i_head.kind == mme_pkg::CMD_QUERY && i_head.len != '0) begin
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (issue) r_k <= r_k + 1'b1;
                    if (done)  r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && !(i_head.kind == mme_pkg::CMD_QUERY && i_head.len != '0)) begin
            r_out_valid <= 1'b1;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out.product_value <= '0;
            r_out.range_error   <= (i_head.kind == mme_pkg::CMD_REJECT);
        end else if (done) begin
            r_out.product_value <= r_acc;
            r_out.range_error   <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

/* design/matrix_multiply_engine.sv */
// Top level of the matrix multiply engine: front end, command queue, back end.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+----------------------------
//  in      | input     | i_in_valid/o_in_stall   | t_in_item  (op,row,col,val)
//  out     | output    | o_out_valid/i_out_stall | t_out_item (product,error)
//  cfg     | input     | i_cfg_we                | i_cfg_index, i_cfg_data
//
// Loads, rejected items and empty-sum queries leave the back end idle and write the
// result register directly; any other query holds it in the run state, one
// multiply-accumulate per cycle, until the read, multiply and accumulate stages drain.
// Reset clears the queue, the sequencer and the result valid; the stores stay
// undefined until loaded. Input stalls only when the two-entry queue is full;
// the back end stalls while i_out_stall holds a result, as every command writes one.
`timescale 1ns / 1ps
`default_nettype none
module matrix_multiply_engine (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [mme_pkg::CfgIdxW-1:0] i_cfg_index,
    input  wire logic [mme_pkg::DimW-1:0]    i_cfg_data,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire mme_pkg::t_in_item           i_in_data,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output mme_pkg::t_out_item               o_out_data
);

    logic               push;
    logic               pop;
    mme_pkg::t_cmd      push_cmd;
    mme_pkg::t_cmd      head;
    mme_pkg::t_q_status q_status;

    mme_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .i_q_status  (q_status),
        .o_in_stall  (o_in_stall),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    mme_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .i_pop      (pop),
        .o_head     (head),
        .o_status   (q_status)
    );

    mme_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_q_status  (q_status),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire

/* design/mme_checker.sv */
// Port-level checker for the matrix multiply engine and its bind.
`timescale 1ns / 1ps
`default_nettype none
module mme_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        o_in_stall,
    input wire logic                        o_out_valid,
    input wire logic                        i_out_stall,
    input wire mme_pkg::t_out_item          o_out_data
);

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // Drop the value on any rejected item.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.range_error |-> o_out_data.product_value == '0)
        else $error("rejected item carries a nonzero product");

    // Reset empties the queue and the result register.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("result or stall active after reset");

endmodule

bind matrix_multiply_engine mme_checker u_mme_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
`default_nettype wire
